// ===== hw/rtl/sidfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot-ID free-list allocator package
// Request and response types, action and status codes, controller states.
// ----------------------------------------------------------------------------
package sidfl_pkg;

	// Action codes; the unused code behaves as a get
	localparam logic [1:0] ACT_PUT = 2'd0;
	localparam logic [1:0] ACT_GET = 2'd1;
	localparam logic [1:0] ACT_DEL = 2'd2;

	// Status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_NO_FREE = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  slot_index;
		logic [31:0] task_handle;
	} req_t;

	typedef struct packed {
		logic [7:0]  given_index;
		logic [31:0] handle_out;
		logic        present;
		logic        full_res;
		logic        status;
	} rsp_t;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

endpackage

// ===== hw/rtl/sidfl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module sidfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/slot_id_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot-ID free-list allocator
// Hands out slot indices from a FIFO of free indices and keeps a task handle
// and an occupied bit per slot; supports put, get and delete requests.
// ----------------------------------------------------------------------------
// In the accept cycle of a request the free-list RAM is read at the head
// pointer and the handle RAM at the addressed slot; in the cycle after, busy
// is high, the read data is used, the RAMs and occupied bits are updated and
// the response is shown with done for that one cycle only. The receiver cannot
// stall, so a new request may follow in the cycle after done. The block is
// ready straight after reset: the free list needs no clearing pass, since
// entries not yet written by a delete read back as their own position. Only
// slots 0..255 are addressable by get and delete, so handles and occupied
// bits are kept for at most 256 slots.
// ----------------------------------------------------------------------------
module slot_id_free_list_allocator_top #(
	parameter int NUM_SLOTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sidfl_pkg::req_t req,
	output logic            done,
	output sidfl_pkg::rsp_t rsp
);

	import sidfl_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int VD = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
	localparam int VW = $clog2(VD);

	state_t          state_q;
	logic [IW-1:0]   head_q;
	logic [IW-1:0]   tail_q;
	logic            wrap_q;
	logic [CW-1:0]   free_count_q;
	logic [VD-1:0]   valid_q;

	req_t            req_s1;
	logic            fq_fill_s1;

	logic            accept;
	logic [IW-1:0]   fq_rdata;
	logic [31:0]     hd_rdata;
	logic [IW-1:0]   slot;
	logic [IW+7:0]   slot_ext;
	logic [IW+7:0]   idx_ext;
	logic            in_range;
	logic [VW-1:0]   vidx;
	logic            idx_valid;
	logic            slot_in_tab;
	logic            is_put;
	logic            is_del;
	logic            put_ok;
	logic            del_ok;
	logic            get_hit;
	logic [CW-1:0]   free_count_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_EXEC);

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture; fill flag says whether the head entry was ever written
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req;
			fq_fill_s1 <= wrap_q || (head_q < tail_q);
		end
	end

	// Free-list RAM: head read on accept, tail write on a successful delete
	sidfl_ram #(
		.WIDTH (IW),
		.DEPTH (NUM_SLOTS)
	) u_free_ram (
		.clk   (clk),
		.we    (del_ok),
		.waddr (tail_q),
		.wdata (idx_ext[IW-1:0]),
		.re    (accept),
		.raddr (head_q),
		.rdata (fq_rdata)
	);

	// Handle RAM: read at the addressed slot, written on a successful put
	sidfl_ram #(
		.WIDTH (32),
		.DEPTH (VD)
	) u_handle_ram (
		.clk   (clk),
		.we    (put_ok && slot_in_tab),
		.waddr (slot[VW-1:0]),
		.wdata (req_s1.task_handle),
		.re    (accept),
		.raddr (req.slot_index[VW-1:0]),
		.rdata (hd_rdata)
	);

	// Execute-cycle decode
	always_comb begin
		slot        = fq_fill_s1 ? fq_rdata : head_q;
		slot_ext    = {8'd0, slot};
		idx_ext     = {{IW{1'b0}}, req_s1.slot_index};
		in_range    = 32'(req_s1.slot_index) < 32'(NUM_SLOTS);
		vidx        = req_s1.slot_index[VW-1:0];
		idx_valid   = in_range && valid_q[vidx];
		slot_in_tab = 32'(slot) < 32'(VD);
		is_put      = (req_s1.action == ACT_PUT);
		is_del      = (req_s1.action == ACT_DEL);
		put_ok      = done && is_put && (free_count_q != '0);
		del_ok      = done && is_del && idx_valid;
		get_hit     = !is_put && !is_del && idx_valid;

		free_count_d = free_count_q;
		if (put_ok) begin
			free_count_d = free_count_q - 1'b1;
		end else if (del_ok) begin
			free_count_d = free_count_q + 1'b1;
		end
	end

	// Response
	always_comb begin
		rsp.given_index = put_ok ? slot_ext[7:0] : req_s1.slot_index;
		rsp.handle_out  = get_hit ? hd_rdata : 32'd0;
		rsp.present     = (is_del || get_hit) && idx_valid;
		rsp.full_res    = (free_count_d == '0);
		rsp.status      = (is_put && (free_count_q == '0)) ? ST_NO_FREE : ST_OK;
	end

	// Pointers, count and occupied bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			wrap_q       <= 1'b0;
			free_count_q <= CW'(NUM_SLOTS);
			valid_q      <= '0;
		end else begin
			free_count_q <= free_count_d;
			if (put_ok) begin
				head_q <= (head_q == IW'(NUM_SLOTS - 1)) ? '0 : head_q + 1'b1;
				if (slot_in_tab) begin
					valid_q[slot[VW-1:0]] <= 1'b1;
				end
			end
			if (del_ok) begin
				valid_q[vidx] <= 1'b0;
				if (tail_q == IW'(NUM_SLOTS - 1)) begin
					tail_q <= '0;
					wrap_q <= 1'b1;
				end else begin
					tail_q <= tail_q + 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	// A response only follows an accepted request
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("done without accepted request");

	// An accepted request keeps the block busy for the update cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after accept");

	// Free count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_count_q) <= 32'(NUM_SLOTS))
		else $error("free count out of range");

	// Empty or full free list means head and tail meet
	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		((free_count_q == '0) || (32'(free_count_q) == 32'(NUM_SLOTS)))
		|-> (head_q == tail_q))
		else $error("head and tail disagree with free count");

	// A refused put always reports the list full
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_NO_FREE)) |-> rsp.full_res)
		else $error("refused put without full");
`endif

endmodule

// ===== dv/slot_id_free_list_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot-ID free-list allocator checker
// Watches the request and response channels of the allocator. For every
// accepted request it works out the expected response from its own copy of
// the free-index ring and the slot table. Each strobed response is then
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module slot_id_free_list_allocator_checker #(
	parameter int NUM_SLOTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  sidfl_pkg::req_t req,
	input  logic            done,
	input  sidfl_pkg::rsp_t rsp,
	output int              mismatches,
	output int              pending
);

	import sidfl_pkg::*;

	// Shadow of the allocator state
	int          free_ring [NUM_SLOTS];
	int          ring_head;
	int          ring_tail;
	int          free_left;
	bit          occupied [NUM_SLOTS];
	logic [31:0] stored_handle [NUM_SLOTS];

	rsp_t expected_rsp_q [$];

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		// keep the log short when the block is badly broken
		if (mismatches < 50)
			$display("%0t ns: allocator mismatch: %s", $time, msg);
		mismatches = mismatches + 1;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Applies one request to the shadow state and returns its response
	function automatic rsp_t predict_slot_response(input req_t r);
		rsp_t p;
		int   slot;
		p.given_index = r.slot_index;
		p.handle_out  = '0;
		p.present     = 1'b0;
		p.status      = ST_OK;
		if (r.action == ACT_PUT) begin
			if (free_left == 0) begin
				p.status = ST_NO_FREE;
			end else begin
				slot = free_ring[ring_head];
				if (slot >= NUM_SLOTS)
					slot = 0;
				ring_head = (ring_head + 1) % NUM_SLOTS;
				free_left = free_left - 1;
				p.present = occupied[slot];
				stored_handle[slot] = r.task_handle;
				occupied[slot] = 1'b1;
				p.given_index = 8'(slot);
			end
		end else if (r.action == ACT_DEL) begin
			if (int'(r.slot_index) < NUM_SLOTS && occupied[r.slot_index]) begin
				p.present = 1'b1;
				occupied[r.slot_index] = 1'b0;
				stored_handle[r.slot_index] = '0;
				free_ring[ring_tail] = r.slot_index;
				ring_tail = (ring_tail + 1) % NUM_SLOTS;
				free_left = free_left + 1;
			end
		end else begin
			// get, and the spare code which reads like a get
			if (int'(r.slot_index) < NUM_SLOTS && occupied[r.slot_index]) begin
				p.present    = 1'b1;
				p.handle_out = stored_handle[r.slot_index];
			end
		end
		p.full_res = (free_left == 0);
		return p;
	endfunction

	// Compare responses first, then record the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				free_ring[i] = i;
				occupied[i] = 1'b0;
				stored_handle[i] = '0;
			end
			ring_head = 0;
			ring_tail = 0;
			free_left = NUM_SLOTS;
			expected_rsp_q.delete();
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response strobed with no request outstanding");
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("given_index", 32'(rsp.given_index), 32'(want.given_index));
					check_field("handle_out", rsp.handle_out, want.handle_out);
					check_field("present", 32'(rsp.present), 32'(want.present));
					check_field("full_res", 32'(rsp.full_res), 32'(want.full_res));
					check_field("status", 32'(rsp.status), 32'(want.status));
				end
			end
			if (start && !busy)
				expected_rsp_q.push_back(predict_slot_response(req));
			pending <= expected_rsp_q.size();
		end
	end

endmodule

// ===== dv/slot_id_free_list_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot-ID free-list allocator testbench
// Drives put, get and delete requests into the allocator: a directed set over
// empty slots, field extremes and the spare action code, then random traffic
// that alternates between filling the table until puts are refused and
// draining it again, under changing amounts of idle time on the request
// side. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module slot_id_free_list_allocator_top_tb;

	import sidfl_pkg::*;

	localparam int          SLOTS        = 256;
	localparam int          RANDOM_ITEMS = 1400;
	localparam logic [1:0]  ACT_SPARE    = 2'd3;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	req_t  req    = '0;
	logic  busy;
	logic  done;
	rsp_t  rsp;
	int    mismatches;
	int    pending;
	int    refusals = 0;

	slot_id_free_list_allocator_top #(
		.NUM_SLOTS(SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	slot_id_free_list_allocator_checker #(
		.NUM_SLOTS(SLOTS)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Refused puts tell the stimulus that the table has filled up
	always @(posedge clk) begin
		if (done === 1'b1 && rsp.status === ST_NO_FREE)
			refusals <= refusals + 1;
	end

	function automatic req_t make_request(input logic [1:0] action,
			input logic [7:0] slot_index, input logic [31:0] task_handle);
		req_t r;
		r.action      = action;
		r.slot_index  = slot_index;
		r.task_handle = task_handle;
		return r;
	endfunction

	// Hold the request up until the block takes it
	task automatic issue(input req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int          idle_pct;
		int          pick;
		int          drain_left;
		int          refusal_mark;
		bit          draining;
		logic [1:0]  action;
		logic [31:0] handle;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty slots, field extremes, spare code, reuse order
		issue(make_request(ACT_GET, 8'd0, 32'h0));
		issue(make_request(ACT_GET, 8'd255, 32'hFFFF_FFFF));
		issue(make_request(ACT_DEL, 8'd7, 32'h0));
		issue(make_request(ACT_SPARE, 8'd0, 32'hFFFF_FFFF));
		issue(make_request(ACT_PUT, 8'd0, 32'h0));
		issue(make_request(ACT_PUT, 8'd0, 32'hFFFF_FFFF));
		issue(make_request(ACT_PUT, 8'd255, 32'hA5A5_A5A5));
		issue(make_request(ACT_GET, 8'd0, 32'hFFFF_FFFF));
		issue(make_request(ACT_GET, 8'd1, 32'h0));
		issue(make_request(ACT_GET, 8'd2, 32'h0));
		issue(make_request(ACT_SPARE, 8'd1, 32'h0));
		issue(make_request(ACT_DEL, 8'd1, 32'hFFFF_FFFF));
		issue(make_request(ACT_GET, 8'd1, 32'h0));
		issue(make_request(ACT_DEL, 8'd1, 32'h0));
		issue(make_request(ACT_PUT, 8'd128, 32'h5A5A_5A5A));
		issue(make_request(ACT_GET, 8'd3, 32'h0));
		issue(make_request(ACT_GET, 8'd255, 32'h0));
		issue(make_request(ACT_DEL, 8'd255, 32'h0));
		issue(make_request(ACT_DEL, 8'd0, 32'h0));
		issue(make_request(ACT_DEL, 8'd2, 32'h0));
		issue(make_request(ACT_SPARE, 8'd255, 32'h0));
		issue(make_request(ACT_GET, 8'd0, 32'h0));

		// Random: fill until puts are refused, then drain for a while
		draining     = 1'b0;
		drain_left   = 0;
		refusal_mark = refusals;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// the receiver cannot stall, so two of the four phases run with no sender idling
			case (n * 4 / RANDOM_ITEMS)
				0:       idle_pct = 0;
				1:       idle_pct = 53;
				2:       idle_pct = 0;
				default: idle_pct = 32;
			endcase

			if (!draining && refusals >= refusal_mark + 6) begin
				draining   = 1'b1;
				drain_left = $urandom_range(400, 250);
			end else if (draining && drain_left == 0) begin
				draining     = 1'b0;
				refusal_mark = refusals;
			end
			if (draining)
				drain_left = drain_left - 1;

			pick = $urandom_range(99);
			if (draining)
				action = (pick < 60) ? ACT_DEL : (pick < 75) ? ACT_PUT :
					(pick < 95) ? ACT_GET : ACT_SPARE;
			else
				action = (pick < 55) ? ACT_PUT : (pick < 75) ? ACT_GET :
					(pick < 95) ? ACT_DEL : ACT_SPARE;

			pick = $urandom_range(9);
			handle = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;

			// idle gaps carry junk on the request bus
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				req   <= make_request(2'($urandom), 8'($urandom), $urandom);
				@(posedge clk);
			end
			issue(make_request(action, 8'($urandom_range(255)), handle));
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("slot_id_free_list_allocator_top_tb passed");
		else
			$display("slot_id_free_list_allocator_top_tb failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("slot_id_free_list_allocator_top_tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/sidfl_pkg.sv
hw/rtl/sidfl_ram.sv
hw/rtl/slot_id_free_list_allocator_top.sv
dv/slot_id_free_list_allocator_checker.sv
dv/slot_id_free_list_allocator_top_tb.sv
